FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tkdpc_pkg.sv
package tkdpc_pkg;

   typedef struct packed {
      logic key_one_level;
      logic key_two_level;
      logic calibrated_mode;
      logic alarm_active;
   } req_type;

   typedef struct packed {
      logic [1:0] stable_keys;
      logic [7:0] brightness_code;
      logic       brightness_update;
      logic       unit_fahrenheit;
      logic       clear_calibration;
      logic       buzzer_mute_start;
      logic       buzzer_mute_end;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_DEBOUNCE_TICKS   = 3'd0,
      CSR_LONG_PRESS_TICKS = 3'd1,
      CSR_MUTE_TICKS       = 3'd2,
      CSR_BRIGHT_ZERO      = 3'd3,
      CSR_BRIGHT_ONE       = 3'd4,
      CSR_BRIGHT_TWO       = 3'd5,
      CSR_HELD_AT_POWER_ON = 3'd6
   } csr_index_type;

   typedef struct packed {
      csr_index_type index;
      logic [15:0]   wdata;
   } csr_type;

   // debounced key codes
   localparam logic [1:0] KEYS_NONE = 2'd0;
   localparam logic [1:0] KEY_ONE   = 2'd1;
   localparam logic [1:0] KEY_TWO   = 2'd2;

   localparam logic [1:0] BRIGHT_LAST = 2'd2;

   localparam logic [7:0]  DEBOUNCE_RESET   = 8'd20;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;
   localparam logic [15:0] MUTE_RESET       = 16'd10000;
   localparam logic [7:0]  BRIGHT_ZERO_RESET = 8'h01;
   localparam logic [7:0]  BRIGHT_ONE_RESET  = 8'h51;
   localparam logic [7:0]  BRIGHT_TWO_RESET  = 8'h21;

endpackage

FILE: sv/tkdpc_intf.sv
interface tkdpc_req_if;
   import tkdpc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tkdpc_rsp_if;
   import tkdpc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tkdpc_csr_if;
   import tkdpc_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/two_key_debounce_press_classifier.sv
// channel    port       direction  beat
// ---------  ---------  ---------  ------------------------------------------
// tick in    req_chan   sink       key levels, calibrated and alarm flags
// result     rsp_chan   source     stable keys, brightness, unit, pulses
// registers  csr_chan   sink       register index and write data, always ready
//
// one beat per cycle sustained while rsp_chan is ready; a tick beat lands in
// the input register and its result moves on into the result register.
// key state advances when a beat moves from the input register to the result.
// reset clears the pipeline, the key state and loads the register defaults.
// a stalled result holds both stages; req_chan.ready drops only when both hold.
module two_key_debounce_press_classifier (
   input logic          clock,
   input logic          reset,
   tkdpc_req_if.sink    req_chan,
   tkdpc_rsp_if.source  rsp_chan,
   tkdpc_csr_if.sink    csr_chan
);
   import tkdpc_pkg::*;

   // registers
   logic [7:0]  debounce_ff;
   logic [15:0] long_press_ff;
   logic [15:0] mute_ticks_ff;
   logic [7:0]  bright_zero_ff;
   logic [7:0]  bright_one_ff;
   logic [7:0]  bright_two_ff;
   logic        held_power_ff;

   // pipeline
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    req_fire;
   logic    out_free;
   logic    advance;

   // key state
   logic [1:0]  stable_code_ff, stable_code_in;
   logic [7:0]  mismatch_count_ff, mismatch_count_in;
   logic [15:0] key_one_hold_ff, key_one_hold_in;
   logic [15:0] key_two_hold_ff, key_two_hold_in;
   logic        short_fired_ff, short_fired_in;
   logic        long_one_fired_ff, long_one_fired_in;
   logic        long_two_fired_ff, long_two_fired_in;
   logic [1:0]  bright_index_ff, bright_index_in;
   logic        unit_mode_ff, unit_mode_in;
   logic        power_hold_used_ff, power_hold_used_in;
   logic        mute_running_ff, mute_running_in;
   logic [15:0] mute_count_ff, mute_count_in;

   logic [1:0]  raw_code;
   logic [7:0]  mismatch_inc;
   logic        upd, clr, mstart, mend;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign advance        = in_valid_ff && out_free;

   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      stable_code_in     = stable_code_ff;
      mismatch_count_in  = mismatch_count_ff;
      key_one_hold_in    = key_one_hold_ff;
      key_two_hold_in    = key_two_hold_ff;
      short_fired_in     = short_fired_ff;
      long_one_fired_in  = long_one_fired_ff;
      long_two_fired_in  = long_two_fired_ff;
      bright_index_in    = bright_index_ff;
      unit_mode_in       = unit_mode_ff;
      power_hold_used_in = power_hold_used_ff;
      mute_running_in    = mute_running_ff;
      mute_count_in      = mute_count_ff;
      upd    = 1'b0;
      clr    = 1'b0;
      mstart = 1'b0;
      mend   = 1'b0;

      // pins are active low
      raw_code     = {~in_data_ff.key_two_level, ~in_data_ff.key_one_level};
      mismatch_inc = mismatch_count_ff + 8'd1;

      // debounce: adopting a new code restarts all press tracking
      if (raw_code != stable_code_ff) begin
         mismatch_count_in = mismatch_inc;
         if (mismatch_inc >= debounce_ff) begin
            mismatch_count_in = '0;
            key_one_hold_in   = '0;
            key_two_hold_in   = '0;
            short_fired_in    = 1'b0;
            long_one_fired_in = 1'b0;
            long_two_fired_in = 1'b0;
            stable_code_in    = raw_code;
         end
      end else begin
         mismatch_count_in = '0;
      end

      if (stable_code_in == KEY_ONE) begin
         if (key_one_hold_in < long_press_ff) begin
            key_one_hold_in = key_one_hold_in + 16'd1;
         end
         // short press fires on the first raw release tick
         if (key_one_hold_in < long_press_ff && !short_fired_in && raw_code != KEY_ONE) begin
            bright_index_in = (bright_index_in >= BRIGHT_LAST) ? 2'd0 : bright_index_in + 2'd1;
            upd             = 1'b1;
            short_fired_in  = 1'b1;
         end
         if (key_one_hold_in >= long_press_ff && !long_one_fired_in) begin
            unit_mode_in      = ~unit_mode_in;
            long_one_fired_in = 1'b1;
         end
      end

      if (stable_code_in == KEY_TWO) begin
         if (key_two_hold_in < long_press_ff) begin
            key_two_hold_in = key_two_hold_in + 16'd1;
         end
         if (in_data_ff.calibrated_mode && held_power_ff && !power_hold_used_in) begin
            clr                = 1'b1;
            power_hold_used_in = 1'b1;
         end
         if (in_data_ff.alarm_active && key_two_hold_in >= long_press_ff &&
             !long_two_fired_in) begin
            mstart            = 1'b1;
            mute_running_in   = 1'b1;
            long_two_fired_in = 1'b1;
         end
      end

      // a retrigger keeps the running count
      if (mute_running_in) begin
         mute_count_in = mute_count_in + 16'd1;
         if (mute_count_in >= mute_ticks_ff) begin
            mute_count_in   = '0;
            mute_running_in = 1'b0;
            mend            = 1'b1;
         end
      end

      rsp_data_in.stable_keys = stable_code_in;
      case (bright_index_in)
         2'd1:    rsp_data_in.brightness_code = bright_one_ff;
         2'd2:    rsp_data_in.brightness_code = bright_two_ff;
         default: rsp_data_in.brightness_code = bright_zero_ff;
      endcase
      rsp_data_in.brightness_update = upd;
      rsp_data_in.unit_fahrenheit   = unit_mode_in;
      rsp_data_in.clear_calibration = clr;
      rsp_data_in.buzzer_mute_start = mstart;
      rsp_data_in.buzzer_mute_end   = mend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         stable_code_ff     <= KEYS_NONE;
         mismatch_count_ff  <= '0;
         key_one_hold_ff    <= '0;
         key_two_hold_ff    <= '0;
         short_fired_ff     <= 1'b0;
         long_one_fired_ff  <= 1'b0;
         long_two_fired_ff  <= 1'b0;
         bright_index_ff    <= '0;
         unit_mode_ff       <= 1'b0;
         power_hold_used_ff <= 1'b0;
         mute_running_ff    <= 1'b0;
         mute_count_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            stable_code_ff     <= stable_code_in;
            mismatch_count_ff  <= mismatch_count_in;
            key_one_hold_ff    <= key_one_hold_in;
            key_two_hold_ff    <= key_two_hold_in;
            short_fired_ff     <= short_fired_in;
            long_one_fired_ff  <= long_one_fired_in;
            long_two_fired_ff  <= long_two_fired_in;
            bright_index_ff    <= bright_index_in;
            unit_mode_ff       <= unit_mode_in;
            power_hold_used_ff <= power_hold_used_in;
            mute_running_ff    <= mute_running_in;
            mute_count_ff      <= mute_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
         mute_ticks_ff  <= MUTE_RESET;
         bright_zero_ff <= BRIGHT_ZERO_RESET;
         bright_one_ff  <= BRIGHT_ONE_RESET;
         bright_two_ff  <= BRIGHT_TWO_RESET;
         held_power_ff  <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.data.index)
            CSR_DEBOUNCE_TICKS:   debounce_ff    <= csr_chan.data.wdata[7:0];
            CSR_LONG_PRESS_TICKS: long_press_ff  <= csr_chan.data.wdata;
            CSR_MUTE_TICKS:       mute_ticks_ff  <= csr_chan.data.wdata;
            CSR_BRIGHT_ZERO:      bright_zero_ff <= csr_chan.data.wdata[7:0];
            CSR_BRIGHT_ONE:       bright_one_ff  <= csr_chan.data.wdata[7:0];
            CSR_BRIGHT_TWO:       bright_two_ff  <= csr_chan.data.wdata[7:0];
            CSR_HELD_AT_POWER_ON: held_power_ff  <= csr_chan.data.wdata[0];
            default: ;
         endcase
      end
   end

`include "assert_macros.svh"

   `ASSERT_IMP(a_bright_only_key_one, clock, reset, rsp_valid_ff && rsp_data_ff.brightness_update, rsp_data_ff.stable_keys == KEY_ONE, "brightness step outside key1 hold")
   `ASSERT_IMP(a_mute_only_key_two, clock, reset, rsp_valid_ff && rsp_data_ff.buzzer_mute_start, rsp_data_ff.stable_keys == KEY_TWO, "mute start outside key2 hold")
   `ASSERT_NXT(a_power_hold_sticky, clock, reset, power_hold_used_ff, power_hold_used_ff, "power-on hold re-armed")
   `ASSERT_IMP(a_bright_index_range, clock, reset, 1'b1, bright_index_ff <= BRIGHT_LAST, "brightness index out of table")

endmodule
